/* rtl/core/spz_pkg.sv */
// Shared types and micro-operation codes for the sponge stream engine.
// No dependencies; used by the controller, the datapath and the top level.
package spz_pkg;

	// Datapath micro-operations issued by the controller, one per cycle
	localparam logic [4:0] OP_NOP  = 5'd0;
	localparam logic [4:0] OP_LOAD = 5'd1;   // capture the incoming data byte
	localparam logic [4:0] OP_U0   = 5'd2;   // i += w, read S[i]
	localparam logic [4:0] OP_U1   = 5'd3;   // hold S[i], read S[j + S[i]]
	localparam logic [4:0] OP_U2   = 5'd4;   // j = k + S[..], read S[j]
	localparam logic [4:0] OP_U3   = 5'd5;   // k = i + k + S[j], write S[i]
	localparam logic [4:0] OP_U4   = 5'd6;   // write S[j]
	localparam logic [4:0] OP_O0   = 5'd7;   // read S[z + k]
	localparam logic [4:0] OP_O1   = 5'd8;   // read S[i + ..]
	localparam logic [4:0] OP_O2   = 5'd9;   // read S[j + ..]
	localparam logic [4:0] OP_O3   = 5'd10;  // z = S[..]
	localparam logic [4:0] OP_A0   = 5'd11;  // read S[a]
	localparam logic [4:0] OP_A1   = 5'd12;  // hold S[a], read S[128 + nibble]
	localparam logic [4:0] OP_A2   = 5'd13;  // write S[a]
	localparam logic [4:0] OP_A3   = 5'd14;  // write S[128 + nibble], a++
	localparam logic [4:0] OP_SEND = 5'd15;  // end of shuffle: w += 2, a = 0
	localparam logic [4:0] OP_EMIT = 5'd16;  // copy z into the output register

	localparam logic [7:0] HALF_N      = 8'd128;
	localparam logic [7:0] STEP_W_INIT = 8'd1;

	typedef struct packed {
		logic [4:0] op;
		logic       nib_hi;   // absorb the high nibble of the held byte
	} spz_cmd_t;

	typedef struct packed {
		logic abs_full;       // absorb count has reached 128
		logic abs_any;        // absorb count is nonzero
	} spz_stat_t;

endpackage

/* rtl/core/spz_if.sv */
// Valid/ready channel interfaces for the sponge stream engine.
// No dependencies.
interface spz_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface spz_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;

	modport source (output valid, output key_byte, input ready);
	modport sink (input valid, input key_byte, output ready);
endinterface

/* rtl/core/spz_datapath.sv */
// Datapath: permutation memory, index registers and output register.
// Depends on spz_pkg; driven one micro-operation per cycle by spz_ctrl.
module spz_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  spz_pkg::spz_cmd_t  cmd,
	input  logic [7:0]         data_byte,
	output spz_pkg::spz_stat_t stat,
	output logic [7:0]         key_byte
);

	// Permutation store; unwritten entries read as their own index
	logic [7:0]   perm_mem [256];
	logic [255:0] valid_q;
	logic [7:0]   mem_rd_q;
	logic [7:0]   raddr_q;
	logic         rvalid_q;

	logic [7:0] i_q, j_q, k_q, w_q, a_q, z_q;
	logic [7:0] tmp_q, byte_q, key_q;

	logic       wr_en;
	logic [7:0] wr_addr, wr_data;
	logic [7:0] rd_addr;
	logic [7:0] rd;
	logic [3:0] nib;
	logic [7:0] nib_addr;

	assign rd       = rvalid_q ? mem_rd_q : raddr_q;
	assign nib      = cmd.nib_hi ? byte_q[7:4] : byte_q[3:0];
	assign nib_addr = spz_pkg::HALF_N | {4'd0, nib};

	// Address and write-port decode
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = rd;
		rd_addr = raddr_q;
		unique case (cmd.op)
			spz_pkg::OP_U0: rd_addr = i_q + w_q;
			spz_pkg::OP_U1: rd_addr = j_q + rd;
			spz_pkg::OP_U2: rd_addr = k_q + rd;
			spz_pkg::OP_U3: begin
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = rd;
			end
			spz_pkg::OP_U4: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = tmp_q;
			end
			spz_pkg::OP_O0: rd_addr = z_q + k_q;
			spz_pkg::OP_O1: rd_addr = i_q + rd;
			spz_pkg::OP_O2: rd_addr = j_q + rd;
			spz_pkg::OP_A0: rd_addr = a_q;
			spz_pkg::OP_A1: rd_addr = nib_addr;
			spz_pkg::OP_A2: begin
				wr_en   = 1'b1;
				wr_addr = a_q;
				wr_data = rd;
			end
			spz_pkg::OP_A3: begin
				wr_en   = 1'b1;
				wr_addr = nib_addr;
				wr_data = tmp_q;
			end
			default: ;
		endcase
	end

	// Memory array: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			perm_mem[wr_addr] <= wr_data;
		end
		mem_rd_q <= perm_mem[rd_addr];
		raddr_q  <= rd_addr;
	end

	// Written-entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rvalid_q <= valid_q[rd_addr];
		end
	end

	// Sponge index state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			w_q <= spz_pkg::STEP_W_INIT;
			a_q <= '0;
			z_q <= '0;
		end else begin
			case (cmd.op)
				spz_pkg::OP_U0:   i_q <= i_q + w_q;
				spz_pkg::OP_U2:   j_q <= k_q + rd;
				spz_pkg::OP_U3:   k_q <= i_q + k_q + rd;
				spz_pkg::OP_O3:   z_q <= rd;
				spz_pkg::OP_A3:   a_q <= a_q + 8'd1;
				spz_pkg::OP_SEND: begin
					w_q <= w_q + 8'd2;
					a_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			spz_pkg::OP_LOAD: byte_q <= data_byte;
			spz_pkg::OP_U1:   tmp_q  <= rd;
			spz_pkg::OP_A1:   tmp_q  <= rd;
			spz_pkg::OP_EMIT: key_q  <= z_q;
			default: ;
		endcase
	end

	assign stat.abs_full = (a_q == spz_pkg::HALF_N);
	assign stat.abs_any  = (a_q != 8'd0);
	assign key_byte      = key_q;

endmodule

/* rtl/core/spz_ctrl.sv */
// Controller: sequences absorb, shuffle, update and output micro-operations.
// Depends on spz_pkg; drives spz_datapath through command and status structs.
module spz_ctrl #(
	parameter int WHIP_ROUNDS = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_mode,
	output logic               out_valid,
	input  logic               out_ready,
	output spz_pkg::spz_cmd_t  cmd,
	input  spz_pkg::spz_stat_t stat
);

	localparam int RW = $clog2(WHIP_ROUNDS + 1);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_NCHK = 5'd1;
	localparam logic [4:0] ST_DCHK = 5'd2;
	localparam logic [4:0] ST_U0   = 5'd3;
	localparam logic [4:0] ST_U1   = 5'd4;
	localparam logic [4:0] ST_U2   = 5'd5;
	localparam logic [4:0] ST_U3   = 5'd6;
	localparam logic [4:0] ST_U4   = 5'd7;
	localparam logic [4:0] ST_SEND = 5'd8;
	localparam logic [4:0] ST_O0   = 5'd9;
	localparam logic [4:0] ST_O1   = 5'd10;
	localparam logic [4:0] ST_O2   = 5'd11;
	localparam logic [4:0] ST_O3   = 5'd12;
	localparam logic [4:0] ST_EMIT = 5'd13;
	localparam logic [4:0] ST_A0   = 5'd14;
	localparam logic [4:0] ST_A1   = 5'd15;
	localparam logic [4:0] ST_A2   = 5'd16;
	localparam logic [4:0] ST_A3   = 5'd17;

	logic [4:0]    state_q, state_d;
	logic          mode_q, mode_d;
	logic          nib_q, nib_d;
	logic          shuf_q, shuf_d;
	logic [RW-1:0] round_q, round_d;
	logic          out_valid_q;
	logic          accept;
	logic          emit;
	logic          last_round;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign emit       = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign last_round = (round_q == RW'(WHIP_ROUNDS - 1));
	assign out_valid  = out_valid_q;

	// Next-state logic
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		nib_d   = nib_q;
		shuf_d  = shuf_q;
		round_d = round_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_d  = in_mode;
					nib_d   = 1'b0;
					state_d = in_mode ? ST_DCHK : ST_NCHK;
				end
			end
			ST_NCHK: begin
				shuf_d  = stat.abs_full;
				round_d = '0;
				state_d = stat.abs_full ? ST_U0 : ST_A0;
			end
			ST_DCHK: begin
				shuf_d  = stat.abs_any;
				round_d = '0;
				state_d = ST_U0;
			end
			ST_U0: state_d = ST_U1;
			ST_U1: state_d = ST_U2;
			ST_U2: state_d = ST_U3;
			ST_U3: state_d = ST_U4;
			ST_U4: begin
				if (!shuf_q) begin
					state_d = ST_O0;
				end else if (last_round) begin
					state_d = ST_SEND;
				end else begin
					round_d = round_q + RW'(1);
					state_d = ST_U0;
				end
			end
			ST_SEND: begin
				shuf_d  = 1'b0;
				state_d = mode_q ? ST_U0 : ST_A0;
			end
			ST_O0: state_d = ST_O1;
			ST_O1: state_d = ST_O2;
			ST_O2: state_d = ST_O3;
			ST_O3: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit) begin
					state_d = ST_IDLE;
				end
			end
			ST_A0: state_d = ST_A1;
			ST_A1: state_d = ST_A2;
			ST_A2: state_d = ST_A3;
			ST_A3: begin
				if (nib_q) begin
					state_d = ST_IDLE;
				end else begin
					nib_d   = 1'b1;
					state_d = ST_NCHK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Micro-operation decode
	always_comb begin
		cmd.nib_hi = nib_q;
		unique case (state_q)
			ST_IDLE: cmd.op = accept ? spz_pkg::OP_LOAD : spz_pkg::OP_NOP;
			ST_U0:   cmd.op = spz_pkg::OP_U0;
			ST_U1:   cmd.op = spz_pkg::OP_U1;
			ST_U2:   cmd.op = spz_pkg::OP_U2;
			ST_U3:   cmd.op = spz_pkg::OP_U3;
			ST_U4:   cmd.op = spz_pkg::OP_U4;
			ST_SEND: cmd.op = spz_pkg::OP_SEND;
			ST_O0:   cmd.op = spz_pkg::OP_O0;
			ST_O1:   cmd.op = spz_pkg::OP_O1;
			ST_O2:   cmd.op = spz_pkg::OP_O2;
			ST_O3:   cmd.op = spz_pkg::OP_O3;
			ST_EMIT: cmd.op = emit ? spz_pkg::OP_EMIT : spz_pkg::OP_NOP;
			ST_A0:   cmd.op = spz_pkg::OP_A0;
			ST_A1:   cmd.op = spz_pkg::OP_A1;
			ST_A2:   cmd.op = spz_pkg::OP_A2;
			ST_A3:   cmd.op = spz_pkg::OP_A3;
			default: cmd.op = spz_pkg::OP_NOP;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= 1'b0;
			nib_q       <= 1'b0;
			shuf_q      <= 1'b0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			nib_q   <= nib_d;
			shuf_q  <= shuf_d;
			round_q <= round_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Checks
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		shuf_q |-> (round_q <= RW'(WHIP_ROUNDS - 1)))
		else $error("shuffle round counter out of range");

	a_send_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == spz_pkg::OP_SEND) |=> !stat.abs_any)
		else $error("absorb count not cleared after shuffle");

	a_absorb_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_A0) |-> !stat.abs_full)
		else $error("absorb swap started with a full absorb count");

	a_output_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_O0) |-> $past(state_q == ST_U4))
		else $error("output step not preceded by an update");

endmodule

/* rtl/core/spritz_sponge_stream_engine.sv */
// Top level of the sponge stream engine: joins controller and datapath.
// Depends on spz_pkg, spz_if.sv (channel interfaces), spz_ctrl, spz_datapath.
//
//   port  | dir  | payload                  | word
//   cmd   | sink | mode, data_byte          | absorb a byte (mode 0) or drip (mode 1)
//   key   | src  | key_byte                 | one keystream byte per drip
//
// One item at a time; the permutation memory sets the pace.
// Absorb: each nibble, low first, is swapped in by A0 to A3. Drip: U0 to U4,
// O0 to O3 and EMIT. A pending shuffle adds WHIP_ROUNDS updates, then SEND.
// Reset is asynchronous; the permutation reads as identity until written.
// A drip waits in its last cycle while the previous key word is unaccepted.
module spritz_sponge_stream_engine #(
	parameter int WHIP_ROUNDS = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	spz_in_if.sink    cmd,
	spz_out_if.source key
);

	spz_pkg::spz_cmd_t  ucmd;
	spz_pkg::spz_stat_t stat;

	spz_ctrl #(
		.WHIP_ROUNDS(WHIP_ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.in_mode  (cmd.mode),
		.out_valid(key.valid),
		.out_ready(key.ready),
		.cmd      (ucmd),
		.stat     (stat)
	);

	spz_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ucmd),
		.data_byte(cmd.data_byte),
		.stat     (stat),
		.key_byte (key.key_byte)
	);

endmodule

/* tb/spritz_sponge_stream_engine_tb.sv */
// Self-checking testbench for the sponge stream engine: absorb/drip words in, key words out.
// Depends on spz_pkg, spz_if.sv and spritz_sponge_stream_engine; keeps its own permutation
// model and checks every key word in order, under random stalls on both channels.
module spritz_sponge_stream_engine_tb;

	localparam int WHIP_ROUNDS = 512;
	localparam int ITEM_TARGET = 550;
	// enough shuffles that the step register wraps at least once
	localparam int SHUFFLE_TARGET = 132;
	localparam int TAIL_CYCLES = 5 * WHIP_ROUNDS + 100;

	localparam logic MODE_ABSORB = 1'b0;
	localparam logic MODE_DRIP   = 1'b1;

	// Keystream predictor plus the queue of key words still owed by the block
	class keystream_board;
		logic [7:0] perm [256];
		logic [7:0] absorb_count, idx_i, idx_j, idx_k, step_w, last_z;
		logic [7:0] owed_keys [$];
		int errors, shuffles, step_wraps, drips, absorbs, keys_checked;

		function new();
			for (int v = 0; v < 256; v++)
				perm[v] = v[7:0];
			absorb_count = '0;
			idx_i = '0;
			idx_j = '0;
			idx_k = '0;
			step_w = spz_pkg::STEP_W_INIT;
			last_z = '0;
		endfunction

		function void swap_perm(logic [7:0] p, logic [7:0] q);
			logic [7:0] t;
			t = perm[p];
			perm[p] = perm[q];
			perm[q] = t;
		endfunction

		function void run_update();
			logic [7:0] y;
			idx_i = idx_i + step_w;
			y = idx_j + perm[idx_i];
			idx_j = idx_k + perm[y];
			idx_k = idx_i + idx_k + perm[idx_j];
			swap_perm(idx_i, idx_j);
		endfunction

		function void shuffle();
			logic [7:0] prev_w;
			repeat (WHIP_ROUNDS) run_update();
			prev_w = step_w;
			step_w = step_w + 8'd2;
			if (step_w < prev_w)
				step_wraps++;
			absorb_count = '0;
			shuffles++;
		endfunction

		// full absorb half forces a shuffle before the nibble goes in
		function void mix_in_nibble(logic [3:0] nib);
			logic [7:0] slot;
			if (absorb_count == spz_pkg::HALF_N)
				shuffle();
			slot = spz_pkg::HALF_N + {4'h0, nib};
			swap_perm(absorb_count, slot);
			absorb_count = absorb_count + 8'd1;
		endfunction

		function void note_command(logic mode, logic [7:0] data);
			logic [7:0] p1, p2, p3;
			if (mode == MODE_ABSORB) begin
				absorbs++;
				mix_in_nibble(data[3:0]);
				mix_in_nibble(data[7:4]);
			end else begin
				drips++;
				if (absorb_count != 8'd0)
					shuffle();
				run_update();
				p1 = last_z + idx_k;
				p2 = idx_i + perm[p1];
				p3 = idx_j + perm[p2];
				last_z = perm[p3];
				owed_keys.push_back(last_z);
			end
		endfunction

		function void check_key(logic [7:0] got);
			logic [7:0] want;
			if (owed_keys.size() == 0) begin
				errors++;
				$display("%0t: key word %02h with none expected", $time, got);
			end else begin
				want = owed_keys.pop_front();
				keys_checked++;
				if (got !== want) begin
					errors++;
					$display("%0t: key_byte expected %02h actual %02h", $time, want, got);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;
	int   items_sent;

	spz_in_if  cmd_ch ();
	spz_out_if key_ch ();

	keystream_board board = new();

	spritz_sponge_stream_engine #(
		.WHIP_ROUNDS(WHIP_ROUNDS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.key   (key_ch)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog
	initial begin
		#60_000_000;
		$display("spritz_sponge_stream_engine: mismatch");
		$finish;
	end

	// Both channels observed at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				board.note_command(cmd_ch.mode, cmd_ch.data_byte);
			if (key_ch.valid && key_ch.ready)
				board.check_key(key_ch.key_byte);
		end
	end

	// Key sink: ready runs and stall bursts, always ready near the end
	initial begin
		int n;
		key_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				@(negedge clk);
				key_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 18);
				@(negedge clk);
				key_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				n = $urandom_range(1, 40);
				@(negedge clk);
				key_ch.ready <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	task automatic send_word(input logic mode, input logic [7:0] data);
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 18);
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid     <= 1'b1;
		cmd_ch.mode      <= mode;
		cmd_ch.data_byte <= data;
		do @(posedge clk); while (!cmd_ch.ready);
		items_sent++;
	endtask

	task automatic absorb_run(input int count);
		for (int b = 0; b < count; b++)
			send_word(MODE_ABSORB, 8'($urandom));
	endtask

	task automatic drip_run(input int count);
		for (int b = 0; b < count; b++)
			send_word(MODE_DRIP, 8'($urandom));
	endtask

	// Stimulus
	initial begin
		int pick;
		cmd_ch.valid     = 1'b0;
		cmd_ch.mode      = MODE_ABSORB;
		cmd_ch.data_byte = 8'h00;
		arst_n = 1'b0;
		quiet = 1'b0;
		items_sent = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed: drips straight from reset, nibble extremes, pending shuffle
		send_word(MODE_DRIP, 8'h00);
		send_word(MODE_DRIP, 8'hff);
		send_word(MODE_ABSORB, 8'h00);
		send_word(MODE_ABSORB, 8'hff);
		send_word(MODE_ABSORB, 8'h0f);
		send_word(MODE_ABSORB, 8'hf0);
		send_word(MODE_DRIP, 8'h00);
		send_word(MODE_DRIP, 8'h5a);
		send_word(MODE_ABSORB, 8'h5a);
		send_word(MODE_ABSORB, 8'ha5);
		send_word(MODE_DRIP, 8'hff);
		send_word(MODE_ABSORB, 8'h80);
		send_word(MODE_DRIP, 8'h01);
		send_word(MODE_DRIP, 8'h7f);
		send_word(MODE_ABSORB, 8'h01);
		send_word(MODE_DRIP, 8'h80);

		// random absorb/drip sequences, occasionally past a full absorb half
		while (!(items_sent >= ITEM_TARGET && board.shuffles >= SHUFFLE_TARGET)) begin
			quiet = (items_sent >= ITEM_TARGET - 60) &&
				(board.shuffles >= SHUFFLE_TARGET - 8);
			pick = $urandom_range(0, 49);
			if (pick == 0) begin
				absorb_run($urandom_range(64, 70));
				drip_run($urandom_range(1, 2));
			end else if (pick < 5) begin
				drip_run($urandom_range(1, 4));
			end else if (pick < 8) begin
				absorb_run($urandom_range(1, 3));
			end else begin
				absorb_run($urandom_range(1, 2));
				drip_run($urandom_range(1, 2));
			end
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b0;

		while (board.owed_keys.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d absorb and %0d drip words, %0d key words checked",
			board.absorbs, board.drips, board.keys_checked);
		$display("%0d shuffles, step register wrapped %0d time(s)",
			board.shuffles, board.step_wraps);
		if (board.errors == 0 && board.owed_keys.size() == 0) begin
			$display("spritz_sponge_stream_engine: match");
		end else begin
			$display("spritz_sponge_stream_engine: mismatch");
		end
		$finish;
	end

endmodule
